// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the correlation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property with the reset as disable condition.
`define SWLC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
// Checked property that holds in reset as well.
`define SWLC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SWLC_ASSERT(lbl, clk, rst_n, prop)
`define SWLC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/swlc_pkg.sv =====
// Shared constants and types of the sliding window lagged correlation block.
package swlc_pkg;

    localparam int RING_DEPTH = 512;
    localparam int MAX_LAG    = 16;
    localparam int WIN_MAX    = 256;

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int DEL_W  = $clog2(MAX_LAG + WIN_MAX);
    localparam int LAG_W  = $clog2(MAX_LAG + 1);
    localparam int SEEN_W = $clog2(MAX_LAG + 2);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REBIN_FACTOR = 2'd2;

    typedef struct packed {
        logic [LAG_W-1:0] dx;
        logic [LAG_W-1:0] dy;
        logic [7:0]       w;
    } t_win_cfg;

    typedef struct packed {
        logic [23:0] sx;
        logic [15:0] sy;
        logic [31:0] sxy;
        logic [39:0] sxx;
        logic [23:0] syy;
    } t_win_sums;

endpackage

// ===== hw/rtl/swlc_window.sv =====
// Event rings in block memory and the pipelined window sum engine.
module swlc_window import swlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [15:0] i_wr_ref,
    input  logic [7:0]  i_wr_hit,
    input  logic        i_start,
    input  t_win_cfg    i_cfg,
    output logic        o_done,
    output t_win_sums   o_sums
);

    logic [15:0]       r_ref_mem [RING_DEPTH];
    logic [7:0]        r_hit_mem [RING_DEPTH];
    logic [AW-1:0]     r_wr_pos;
    logic [FILL_W-1:0] r_fill;

    logic              r_issue;
    logic [7:0]        r_left;
    logic [AW-1:0]     r_x_addr, r_y_addr;
    logic [DEL_W-1:0]  r_x_del, r_y_del;

    logic              r_s1_vld, r_s1_last, r_s1_xv, r_s1_yv;
    logic [15:0]       r_ref_q;
    logic [7:0]        r_hit_q;

    logic              r_s2_vld, r_s2_last;
    logic [15:0]       r_px;
    logic [7:0]        r_py;
    logic [31:0]       r_pxx;
    logic [23:0]       r_pxy;
    logic [15:0]       r_pyy;

    logic              r_done;
    t_win_sums         r_sums;
    logic [15:0]       x_val;
    logic [7:0]        y_val;

    // Write pointer and fill count; an entry older than the fill count reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_fill   <= '0;
        end else if (i_wr_en) begin
            r_wr_pos <= r_wr_pos + AW'(1);
            if (r_fill != FILL_W'(RING_DEPTH)) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ref_mem[r_wr_pos] <= i_wr_ref;
            r_hit_mem[r_wr_pos] <= i_wr_hit;
        end
        r_ref_q <= r_ref_mem[r_x_addr];
        r_hit_q <= r_hit_mem[r_y_addr];
    end

    // Address issue: the newest event sits one below the write pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
        end else if (i_start) begin
            r_issue <= 1'b1;
        end else if (r_issue && r_left == 8'd0) begin
            r_issue <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_left   <= i_cfg.w;
            r_x_addr <= r_wr_pos - AW'(i_cfg.dx) - AW'(1);
            r_y_addr <= r_wr_pos - AW'(i_cfg.dy) - AW'(1);
            r_x_del  <= DEL_W'(i_cfg.dx);
            r_y_del  <= DEL_W'(i_cfg.dy);
        end else if (r_issue) begin
            r_left   <= r_left - 8'd1;
            r_x_addr <= r_x_addr - AW'(1);
            r_y_addr <= r_y_addr - AW'(1);
            r_x_del  <= r_x_del + DEL_W'(1);
            r_y_del  <= r_y_del + DEL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld <= r_issue;
            r_s2_vld <= r_s1_vld;
            r_done   <= r_s2_vld && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= r_issue && r_left == 8'd0;
        r_s1_xv   <= 32'(r_x_del) < 32'(r_fill);
        r_s1_yv   <= 32'(r_y_del) < 32'(r_fill);
    end

    assign x_val = r_s1_xv ? r_ref_q : 16'd0;
    assign y_val = r_s1_yv ? r_hit_q : 8'd0;

    always_ff @(posedge i_clk) begin
        r_s2_last <= r_s1_last;
        r_px      <= x_val;
        r_py      <= y_val;
        r_pxx     <= x_val * x_val;
        r_pxy     <= x_val * y_val;
        r_pyy     <= y_val * y_val;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sums <= '0;
        end else if (r_s2_vld) begin
            r_sums.sx  <= r_sums.sx + 24'(r_px);
            r_sums.sy  <= r_sums.sy + 16'(r_py);
            r_sums.sxy <= r_sums.sxy + 32'(r_pxy);
            r_sums.sxx <= r_sums.sxx + 40'(r_pxx);
            r_sums.syy <= r_sums.syy + 24'(r_pyy);
        end
    end

    assign o_done = r_done;
    assign o_sums = r_sums;

endmodule

// ===== hw/rtl/swlc_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
module swlc_sqrt import swlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] rem_sh, trial;
    logic        ge;

    assign rem_sh = {r_rem, r_rad[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_cnt == 5'd31;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 5'd1;
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= ge ? 34'(rem_sh - trial) : 34'(rem_sh);
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/swlc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module swlc_div import swlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [31:0] r_rem, r_dvs;
    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem, r_q[63]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_cnt == 6'd63;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_dvs}) : 32'(rem_sh);
            r_q   <= {r_q[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hw/rtl/sliding_window_lagged_correlation.sv =====
// Sliding window lagged Pearson correlation. Each input transfer carries one event
// (reference value and hit count); the event is stored in two ring memories and the
// block then pairs reference sample i with hit sample i+lag, recomputes the sums over
// the last window_len+1 pairs by reading both rings once per pair, and forms the
// coefficient in signed Q1.15 with two bit-serial square roots and a shared bit-serial
// divider. Coefficients are averaged in groups of rebin_factor; one output transfer
// leaves per closed group. Each event first has its window sums computed from both rings.
// When the window is full and both variances are nonzero, the products and then the
// differences are formed, the two square roots run side by side and two divisions
// follow on the shared divider. The coefficient is then added to its group; when the
// group closes, the divider forms the average and the output register is loaded. The
// run time is set by the single read port of each ring and the one-bit-per-cycle
// divider. An event that forms no pair because of a positive lag goes straight back
// to idle. The next input transfer is taken while a finished result still waits in
// the output register; a closing group waits until that result has left. Samples
// older than the start of the run read as zero through a fill count, so no clearing
// pass follows reset. Configuration writes are taken on any cycle and apply from the
// next accepted event.
`include "assert_macros.svh"
module sliding_window_lagged_correlation import swlc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // [15:0] ref_value, [23:16] pixel_hits
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [15:0] corr
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_SUM    = 4'd2;
    localparam logic [3:0] ST_PROD   = 4'd3;
    localparam logic [3:0] ST_DIFF   = 4'd4;
    localparam logic [3:0] ST_SQRT   = 4'd5;
    localparam logic [3:0] ST_DIV1   = 4'd6;
    localparam logic [3:0] ST_DIV2   = 4'd7;
    localparam logic [3:0] ST_GROUP  = 4'd8;
    localparam logic [3:0] ST_DIV3   = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;

    localparam logic [63:0] CLAMP40 = 64'd1 << 40;

    // Configuration registers.
    logic [7:0] r_window_len;
    logic [5:0] r_lag;
    logic [4:0] r_rebin;

    // Effective settings latched per event.
    logic [7:0]       r_w;
    logic [8:0]       r_n;
    logic [4:0]       r_reb;
    logic [LAG_W-1:0] r_dx, r_dy;
    logic [7:0]       w_eff;
    logic [4:0]       reb_eff;
    logic [LAG_W-1:0] dx_eff, dy_eff;

    logic [3:0]        r_state;
    logic [SEEN_W-1:0] r_seen;
    logic [9:0]        r_pair_cnt;
    logic signed [19:0] r_acc;
    logic [3:0]        r_gcnt;
    logic signed [15:0] r_coef;
    logic [15:0]       r_avg;
    logic              r_acc_neg;

    logic [48:0] r_t1;
    logic [47:0] r_t2;
    logic [32:0] r_u1;
    logic [31:0] r_u2;
    logic [40:0] r_p;
    logic [39:0] r_q;
    logic [40:0] r_mag;
    logic        r_neg;

    logic        r_out_vld;
    logic [15:0] r_out_data;

    logic        accept;
    logic        win_start, win_done;
    t_win_cfg    win_cfg;
    t_win_sums   sums;

    logic [48:0] vx;
    logic [32:0] vy;
    logic [40:0] mag;
    logic        sq_start, sqx_done, sqy_done;
    logic [31:0] rx, ry;

    logic        div_start, div_done;
    logic [63:0] div_dvd, div_quot;
    logic [31:0] div_dvs;

    logic signed [19:0] acc_new;
    logic [19:0]        acc_abs;
    logic [4:0]         held;
    logic [63:0]        a_clamp;
    logic [15:0]        coef_sat, avg_sat;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = r_state == ST_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= 8'd50;
            r_lag        <= 6'd0;
            r_rebin      <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_LEN:   r_window_len <= i_cfg_data;
                CFG_LAG:          r_lag        <= i_cfg_data[5:0];
                CFG_REBIN_FACTOR: r_rebin      <= i_cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    // Out-of-range settings fold onto the nearest legal value.
    always_comb begin
        int lag_i;
        lag_i   = int'($signed(r_lag));
        w_eff   = (r_window_len == 8'd0) ? 8'd1 : r_window_len;
        reb_eff = (r_rebin == 5'd0) ? 5'd1 : ((r_rebin > 5'd16) ? 5'd16 : r_rebin);
        dx_eff  = '0;
        dy_eff  = '0;
        if (lag_i > 0) begin
            dx_eff = LAG_W'((lag_i > MAX_LAG) ? MAX_LAG : lag_i);
        end else if (lag_i < 0) begin
            dy_eff = LAG_W'((-lag_i > MAX_LAG) ? MAX_LAG : -lag_i);
        end
    end

    assign win_cfg   = '{dx: r_dx, dy: r_dy, w: r_w};
    assign win_start = (r_state == ST_DECIDE) && (32'(r_seen) > 32'(r_dx));

    swlc_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (accept),
        .i_wr_ref (s_axis_tdata[15:0]),
        .i_wr_hit (s_axis_tdata[23:16]),
        .i_start  (win_start),
        .i_cfg    (win_cfg),
        .o_done   (win_done),
        .o_sums   (sums)
    );

    // Variances and covariance from the registered products.
    assign vx  = (r_t1 > 49'(r_t2)) ? r_t1 - 49'(r_t2) : 49'd0;
    assign vy  = (r_u1 > 33'(r_u2)) ? r_u1 - 33'(r_u2) : 33'd0;
    assign mag = (r_p < 41'(r_q)) ? 41'(r_q) - r_p : r_p - 41'(r_q);

    assign sq_start = (r_state == ST_DIFF) && vx != '0 && vy != '0;

    swlc_sqrt u_sqrt_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (64'(vx) << 14),
        .o_done  (sqx_done),
        .o_root  (rx)
    );

    swlc_sqrt u_sqrt_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (64'(vy) << 30),
        .o_done  (sqy_done),
        .o_root  (ry)
    );

    assign a_clamp = (div_quot > CLAMP40) ? CLAMP40 : div_quot;
    assign acc_new = r_acc + 20'(r_coef);
    assign acc_abs = acc_new[19] ? 20'(-acc_new) : 20'(acc_new);
    assign held    = 5'(r_gcnt) + 5'd1;

    // One divider serves the two coefficient divisions and the group average.
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = 32'd1;
        case (r_state)
            ST_SQRT: begin
                div_start = sqx_done;
                div_dvd   = 64'(r_mag) << 22;
                div_dvs   = rx;
            end
            ST_DIV1: begin
                div_start = div_done;
                div_dvd   = a_clamp << 15;
                div_dvs   = ry;
            end
            ST_GROUP: begin
                div_start = held >= r_reb;
                div_dvd   = 64'(acc_abs);
                div_dvs   = 32'(held);
            end
            default: ;
        endcase
    end

    swlc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Saturation of the signed magnitude to Q1.15.
    always_comb begin
        if (r_neg) begin
            coef_sat = (div_quot > 64'd32768) ? 16'h8000 : 16'(~div_quot + 64'd1);
        end else begin
            coef_sat = (div_quot > 64'd32767) ? 16'h7fff : div_quot[15:0];
        end
        if (r_acc_neg) begin
            avg_sat = (div_quot > 64'd32768) ? 16'h8000 : 16'(~div_quot + 64'd1);
        end else begin
            avg_sat = (div_quot > 64'd32767) ? 16'h7fff : div_quot[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_seen     <= '0;
            r_pair_cnt <= '0;
            r_acc      <= '0;
            r_gcnt     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            // A closing group reloads the output register; otherwise a transfer empties it.
            if (r_state == ST_EMIT && (!r_out_vld || m_axis_tready)) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (r_seen != SEEN_W'(MAX_LAG + 1)) begin
                            r_seen <= r_seen + SEEN_W'(1);
                        end
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (win_start) begin
                        if (r_pair_cnt != 10'd1023) begin
                            r_pair_cnt <= r_pair_cnt + 10'd1;
                        end
                        r_state <= ST_SUM;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SUM: begin
                    if (win_done) begin
                        r_state <= (r_pair_cnt >= 10'(r_n)) ? ST_PROD : ST_GROUP;
                    end
                end
                ST_PROD:  r_state <= ST_DIFF;
                ST_DIFF:  r_state <= sq_start ? ST_SQRT : ST_GROUP;
                ST_SQRT: begin
                    if (sqx_done) begin
                        r_state <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        r_state <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    if (div_done) begin
                        r_state <= ST_GROUP;
                    end
                end
                ST_GROUP: begin
                    r_acc <= acc_new;
                    if (held >= r_reb) begin
                        r_state <= ST_DIV3;
                    end else begin
                        r_gcnt  <= held[3:0];
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIV3: begin
                    if (div_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_acc     <= '0;
                        r_gcnt    <= '0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w   <= w_eff;
            r_n   <= 9'(w_eff) + 9'd1;
            r_reb <= reb_eff;
            r_dx  <= dx_eff;
            r_dy  <= dy_eff;
        end
        if (r_state == ST_SUM) begin
            r_coef <= '0;
        end
        if (r_state == ST_PROD) begin
            r_t1 <= r_n * sums.sxx;
            r_t2 <= sums.sx * sums.sx;
            r_u1 <= r_n * sums.syy;
            r_u2 <= sums.sy * sums.sy;
            r_p  <= r_n * sums.sxy;
            r_q  <= sums.sx * sums.sy;
        end
        if (r_state == ST_DIFF) begin
            r_neg <= r_p < 41'(r_q);
            r_mag <= (64'(mag) > CLAMP40) ? 41'(CLAMP40) : mag;
        end
        if (r_state == ST_DIV2 && div_done) begin
            r_coef <= coef_sat;
        end
        if (r_state == ST_GROUP) begin
            r_acc_neg <= acc_new[19];
        end
        if (r_state == ST_DIV3 && div_done) begin
            r_avg <= avg_sat;
        end
        if (r_state == ST_EMIT && (!r_out_vld || m_axis_tready)) begin
            r_out_data <= r_avg;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    `SWLC_ASSERT(a_out_from_emit, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(r_state) == ST_EMIT)
    `SWLC_ASSERT(a_win_done_in_sum, i_clk, i_rst_n, win_done |-> r_state == ST_SUM)
    `SWLC_ASSERT(a_sqrt_lockstep, i_clk, i_rst_n, sqx_done == sqy_done)
    `SWLC_ASSERT(a_div_done_state, i_clk, i_rst_n, div_done |-> (r_state == ST_DIV1 || r_state == ST_DIV2 || r_state == ST_DIV3))

endmodule
